FILE: hw/rtl/semr_pkg.sv
package semr_pkg;

  // Line store depth; also the largest usable frame width.
  localparam int MAX_WIDTH = 2048;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int WID_W     = $clog2(MAX_WIDTH + 1);

  localparam int FW_W       = 12;
  localparam int FH_W       = 16;
  localparam int ROW_W      = 17;
  localparam int CFG_DATA_W = 16;

  localparam int NUM_CH  = 3;
  localparam int CH_W    = 8;
  localparam int PIX_W   = NUM_CH * CH_W;
  localparam int KSUM_W  = CH_W + 2;
  localparam int GRAD_W  = KSUM_W + 1;
  localparam int SUM_W   = 2 * GRAD_W - 1;
  localparam int MAG_STEPS = CH_W;

  localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = FW_W'(640);
  localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = FH_W'(480);

  // channel slots inside a pixel word
  localparam int CH_RED   = 2;
  localparam int CH_GREEN = 1;
  localparam int CH_BLUE  = 0;

  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef logic [PIX_W-1:0] pix_t;

  typedef struct packed {
    pix_t top;
    pix_t mid;
    pix_t bot;
  } column_t;

  typedef struct packed {
    logic    last;
    column_t lft;
    column_t ctr;
    column_t rgt;
  } win_t;

  typedef struct packed {
    logic                        last;
    logic [NUM_CH-1:0][SUM_W-1:0] sum;
  } sum_t;

  typedef struct packed {
    logic                         last;
    logic [NUM_CH-1:0][SUM_W-1:0] sum;
    logic [NUM_CH-1:0][CH_W-1:0]  mag;
  } mag_t;

endpackage

FILE: hw/rtl/sobel_edge_magnitude_rgb.sv
// Sobel edge magnitude on an RGB raster stream with a 3x3 window and a black
// border. Pixels go in raster order for a frame of frame_width by
// frame_height (width clamped to 1..2048, height 0 read as 1); after the frame,
// width+1 flush items (kind=1), with the clamped width, drain the remaining
// results, and the result for the frame's last pixel carries frame_end. The
// first width+1 items of a frame give no result; from then on each item gives
// one. Each channel's result is round(sqrt(gx^2+gy^2)) capped at 255. The
// block takes one item per clock while in_stall is low; an item that completes
// a window passes the line store read, the window cells, the gradient and its
// squares, and eight mag cells that settle one result bit each, before its
// result leaves. in_stall rises only while a result waits with out_stall high.
// Configuration writes are taken in any cycle.
module sobel_edge_magnitude_rgb import semr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  kind,
  input  logic [CH_W-1:0]       red_in,
  input  logic [CH_W-1:0]       green_in,
  input  logic [CH_W-1:0]       blue_in,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [CH_W-1:0]       red_out,
  output logic [CH_W-1:0]       green_out,
  output logic [CH_W-1:0]       blue_out,
  output logic                  frame_end,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [0:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic             en;
  logic             in_acc;
  logic [FW_W-1:0]  frame_width;
  logic [FH_W-1:0]  frame_height;
  logic [COL_W-1:0] column_count;
  logic [ROW_W-1:0] row_count;
  logic [COL_W-1:0] column_count_next;
  logic [ROW_W-1:0] row_count_next;

  logic [WID_W-1:0] w_eff;
  logic [FH_W-1:0]  h_eff;
  logic [COL_W-1:0] c_eff;
  logic             top_ok;
  logic             mid_ok;
  logic             acc_last;
  logic             acc_emit;
  logic             row_wrap;
  logic             black;

  logic             s1_valid;
  logic [COL_W-1:0] s1_addr;
  pix_t             s1_px;
  logic             s1_top_ok;
  logic             s1_mid_ok;
  logic             s1_first;
  logic             s1_emit;
  logic             s1_last;

  pix_t    rd_above;
  pix_t    rd_two;
  column_t fresh;

  logic win_valid;
  win_t win_q;
  logic sum_valid;
  sum_t sum_q;

  logic chain_valid [MAG_STEPS+1];
  mag_t chain       [MAG_STEPS+1];

  assign en        = !(out_valid && out_stall);
  assign in_stall  = !en;
  assign in_acc    = in_valid && en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RST;
      frame_height <= FRAME_HEIGHT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_FRAME_WIDTH:  frame_width  <= cfg_data[FW_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= cfg_data[FH_W-1:0];
      endcase
    end
  end

  always_comb begin
    if (frame_width == '0) begin
      w_eff = WID_W'(1);
    end else if (int'(frame_width) > MAX_WIDTH) begin
      w_eff = WID_W'(MAX_WIDTH);
    end else begin
      w_eff = WID_W'(frame_width);
    end
    h_eff = (frame_height == '0) ? FH_W'(1) : frame_height;
    // width lowered mid-row: treat as the last column
    c_eff = (WID_W'(column_count) >= w_eff) ? COL_W'(w_eff - WID_W'(1)) : column_count;

    top_ok   = row_count >= ROW_W'(2);
    mid_ok   = (row_count >= ROW_W'(1)) && (row_count <= ROW_W'(h_eff));
    acc_last = row_count >= ROW_W'(h_eff) + ROW_W'(1);
    acc_emit = (row_count >= ROW_W'(2)) || ((row_count == ROW_W'(1)) && (c_eff != '0));
    row_wrap = (WID_W'(c_eff) + WID_W'(1)) >= w_eff;
    black    = kind || (row_count >= ROW_W'(h_eff));

    if (acc_last) begin
      column_count_next = '0;
      row_count_next    = '0;
    end else if (row_wrap) begin
      column_count_next = '0;
      row_count_next    = row_count + ROW_W'(1);
    end else begin
      column_count_next = c_eff + COL_W'(1);
      row_count_next    = row_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      s1_valid     <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
      if (in_valid) begin
        column_count <= column_count_next;
        row_count    <= row_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_addr   <= c_eff;
      s1_px     <= black ? '0 : {red_in, green_in, blue_in};
      s1_top_ok <= top_ok;
      s1_mid_ok <= mid_ok;
      s1_first  <= (c_eff == '0);
      s1_emit   <= acc_emit;
      s1_last   <= acc_last;
    end
  end

  semr_line_store u_line_store (
    .clk      (clk),
    .rd_en    (in_acc),
    .rd_addr  (c_eff),
    .wr_en    (en && s1_valid),
    .wr_addr  (s1_addr),
    .wr_above (s1_px),
    .wr_two   (fresh.mid),
    .rd_above (rd_above),
    .rd_two   (rd_two)
  );

  // unwritten line store entries are masked to black by the row flags
  assign fresh.top = s1_top_ok ? rd_two : '0;
  assign fresh.mid = s1_mid_ok ? rd_above : '0;
  assign fresh.bot = s1_px;

  semr_window u_window (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .d_valid   (s1_valid),
    .col_first (s1_first),
    .emit      (s1_emit),
    .last      (s1_last),
    .fresh     (fresh),
    .q_valid   (win_valid),
    .q         (win_q)
  );

  semr_grad u_grad (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .d_valid (win_valid),
    .d       (win_q),
    .q_valid (sum_valid),
    .q       (sum_q)
  );

  assign chain_valid[0] = sum_valid;
  assign chain[0].last  = sum_q.last;
  assign chain[0].sum   = sum_q.sum;
  assign chain[0].mag   = '0;

  for (genvar k = 0; k < MAG_STEPS; k++) begin : g_mag
    semr_mag_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .probe   (CH_W'(1 << (MAG_STEPS - 1 - k))),
      .d_valid (chain_valid[k]),
      .d       (chain[k]),
      .q_valid (chain_valid[k+1]),
      .q       (chain[k+1])
    );
  end

  assign out_valid = chain_valid[MAG_STEPS];
  assign red_out   = chain[MAG_STEPS].mag[CH_RED];
  assign green_out = chain[MAG_STEPS].mag[CH_GREEN];
  assign blue_out  = chain[MAG_STEPS].mag[CH_BLUE];
  assign frame_end = chain[MAG_STEPS].last;

`ifndef NO_ASSERTIONS
  a_frame_wrap: assert property (@(posedge clk) disable iff (rst)
    in_acc && acc_last |=> (column_count == '0) && (row_count == '0))
    else $error("counters not cleared after the frame's last item");

  a_row_step: assert property (@(posedge clk) disable iff (rst)
    in_acc && !acc_last && row_wrap
    |=> (column_count == '0) && (row_count == $past(row_count) + ROW_W'(1)))
    else $error("row advance wrong at end of row");

  a_col_step: assert property (@(posedge clk) disable iff (rst)
    in_acc && !acc_last && !row_wrap
    |=> (column_count == $past(c_eff) + COL_W'(1)) && $stable(row_count))
    else $error("column advance wrong inside a row");
`endif

endmodule

FILE: hw/rtl/semr_line_store.sv
module semr_line_store import semr_pkg::*; (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [COL_W-1:0] rd_addr,
  input  logic             wr_en,
  input  logic [COL_W-1:0] wr_addr,
  input  pix_t             wr_above,
  input  pix_t             wr_two,
  output pix_t             rd_above,
  output pix_t             rd_two
);

  pix_t above_mem [MAX_WIDTH];
  pix_t two_mem   [MAX_WIDTH];

  pix_t above_q;
  pix_t two_q;
  pix_t byp_above;
  pix_t byp_two;
  logic byp_hit;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      above_mem[wr_addr] <= wr_above;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      two_mem[wr_addr] <= wr_two;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      above_q <= above_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      two_q <= two_mem[rd_addr];
    end
  end

  // read and write of the same entry at one edge (width 1): forward the new data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      byp_hit   <= wr_en && (rd_addr == wr_addr);
      byp_above <= wr_above;
      byp_two   <= wr_two;
    end
  end

  assign rd_above = byp_hit ? byp_above : above_q;
  assign rd_two   = byp_hit ? byp_two   : two_q;

endmodule

FILE: hw/rtl/semr_window.sv
module semr_window import semr_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    en,
  input  logic    d_valid,
  input  logic    col_first,
  input  logic    emit,
  input  logic    last,
  input  column_t fresh,
  output logic    q_valid,
  output win_t    q
);

  // two column cells; the third column is the fresh one
  column_t col1;
  column_t col2;

  always_ff @(posedge clk) begin
    if (rst) begin
      col1    <= '0;
      col2    <= '0;
      q_valid <= 1'b0;
    end else if (en) begin
      q_valid <= d_valid && emit;
      if (d_valid) begin
        col1 <= col_first ? '0 : col2;
        col2 <= fresh;
      end
    end
  end

  // at the start of a row the window still shows the previous row's last
  // column, with black to its right
  always_ff @(posedge clk) begin
    if (en && d_valid) begin
      q.last <= last;
      q.lft  <= col1;
      q.ctr  <= col2;
      q.rgt  <= col_first ? '0 : fresh;
    end
  end

endmodule

FILE: hw/rtl/semr_grad.sv
module semr_grad import semr_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic d_valid,
  input  win_t d,
  output logic q_valid,
  output sum_t q
);

  logic                     ga_valid;
  logic                     ga_last;
  logic signed [GRAD_W-1:0] gx      [NUM_CH];
  logic signed [GRAD_W-1:0] gy      [NUM_CH];
  logic signed [GRAD_W-1:0] gx_next [NUM_CH];
  logic signed [GRAD_W-1:0] gy_next [NUM_CH];
  logic signed [2*GRAD_W-1:0] sqx   [NUM_CH];
  logic signed [2*GRAD_W-1:0] sqy   [NUM_CH];

  // a + 2b + c on one channel
  function automatic logic [KSUM_W-1:0] wsum(pix_t a, pix_t b, pix_t c, int ch);
    logic [CH_W-1:0] x;
    logic [CH_W-1:0] y;
    logic [CH_W-1:0] z;
    x = a[ch*CH_W +: CH_W];
    y = b[ch*CH_W +: CH_W];
    z = c[ch*CH_W +: CH_W];
    return KSUM_W'(x) + (KSUM_W'(y) << 1) + KSUM_W'(z);
  endfunction

  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      gx_next[i] = $signed({1'b0, wsum(d.rgt.top, d.rgt.mid, d.rgt.bot, i)})
                 - $signed({1'b0, wsum(d.lft.top, d.lft.mid, d.lft.bot, i)});
      gy_next[i] = $signed({1'b0, wsum(d.lft.bot, d.ctr.bot, d.rgt.bot, i)})
                 - $signed({1'b0, wsum(d.lft.top, d.ctr.top, d.rgt.top, i)});
      sqx[i] = gx[i] * gx[i];
      sqy[i] = gy[i] * gy[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ga_valid <= 1'b0;
      q_valid  <= 1'b0;
    end else if (en) begin
      ga_valid <= d_valid;
      q_valid  <= ga_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ga_last <= d.last;
      gx      <= gx_next;
      gy      <= gy_next;
      q.last  <= ga_last;
      for (int i = 0; i < NUM_CH; i++) begin
        q.sum[i] <= sqx[i][SUM_W-1:0] + sqy[i][SUM_W-1:0];
      end
    end
  end

endmodule

FILE: hw/rtl/semr_mag_cell.sv
module semr_mag_cell import semr_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic [CH_W-1:0] probe,
  input  logic            d_valid,
  input  mag_t            d,
  output logic            q_valid,
  output mag_t            q
);

  logic [CH_W-1:0]   t      [NUM_CH];
  logic [2*CH_W-1:0] sq     [NUM_CH];
  logic [2*CH_W-1:0] lhs    [NUM_CH];
  logic [NUM_CH-1:0][CH_W-1:0] mag_next;

  // keep the probe bit if (n|bit)^2 - (n|bit) is still below the sum
  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      t[i]   = d.mag[i] | probe;
      sq[i]  = (2*CH_W)'(t[i]) * (2*CH_W)'(t[i]);
      lhs[i] = sq[i] - (2*CH_W)'(t[i]);
      mag_next[i] = (SUM_W'(lhs[i]) < d.sum[i]) ? t[i] : d.mag[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (en) begin
      q_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q.last <= d.last;
      q.sum  <= d.sum;
      q.mag  <= mag_next;
    end
  end

endmodule
